>>> src/ppfu_pkg.sv
// Shared constants, types and command/status structs of the pixel packet frame updater.
package ppfu_pkg;

	localparam int WINDOWS_PER_PART = 52;
	localparam int WINDOWS_PER_ROW  = 16;
	localparam int FRAME_HEIGHT     = 26;
	localparam int PACKET_BYTES     = 314;

	localparam int FRAME_WIDTH   = 2 * WINDOWS_PER_ROW;
	localparam int FRAME_WINDOWS = WINDOWS_PER_ROW * (FRAME_HEIGHT / 2);
	localparam int FIT_PARTS     = FRAME_WINDOWS / WINDOWS_PER_PART;
	localparam int MAX_PART      = (FIT_PARTS > 7) ? 7 : FIT_PARTS;

	localparam int WIN_BYTES = 6;
	localparam int WIN_BITS  = WIN_BYTES * 8;
	localparam int PIX_BITS  = 12;

	localparam int CNT_W  = $clog2(PACKET_BYTES + 2);
	localparam int WIDX_W = $clog2(WINDOWS_PER_PART + 1);
	localparam int STG_AW = (WINDOWS_PER_PART > 1) ? $clog2(WINDOWS_PER_PART) : 1;
	localparam int FRM_AW = (FRAME_WINDOWS > 1) ? $clog2(FRAME_WINDOWS) : 1;

	localparam logic [7:0] HEADER_VALUE = 8'h01;
	localparam logic [7:0] MAX_PART_B   = 8'(MAX_PART);

	typedef enum logic [1:0] {
		ST_OK_COMMIT  = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_BAD_HEADER = 2'd2,
		ST_PIXEL_DATA = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COMMIT,
		S_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic byte_take;
		logic read_issue;
		logic commit_start;
		logic commit_step;
		logic load_reject;
		logic load_read;
		logic load_commit;
	} dp_cmd_t;

	typedef struct packed {
		logic pkt_good;
		logic rd_last;
	} dp_sts_t;

endpackage

>>> src/ppfu_ctrl.sv
// Controller state machine: handshakes, packet end handling and commit sequencing.
module ppfu_ctrl
	import ppfu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  logic    action,
	input  logic    last_byte,
	output logic    result_valid,
	input  logic    result_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_nxt;
	logic        res_valid_q;
	logic        acc;
	logic        res_load;

	assign item_stall   = (state_q != S_IDLE) || res_valid_q;
	assign acc          = item_valid && !item_stall;
	assign result_valid = res_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (action) begin
						state_nxt = S_READ;
					end else if (last_byte && sts.pkt_good) begin
						state_nxt = S_COMMIT;
					end
				end
			end
			S_READ:   state_nxt = S_IDLE;
			S_COMMIT: begin
				if (sts.rd_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN:  state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.read_issue   = acc && action;
				cmd.byte_take    = acc && !action;
				cmd.commit_start = acc && !action && last_byte && sts.pkt_good;
				cmd.load_reject  = acc && !action && last_byte && !sts.pkt_good;
			end
			S_READ:   cmd.load_read   = 1'b1;
			S_COMMIT: cmd.commit_step = 1'b1;
			S_DRAIN:  cmd.load_commit = 1'b1;
			default:  cmd = '0;
		endcase
	end

	assign res_load = cmd.load_reject || cmd.load_read || cmd.load_commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output register must be empty whenever a new result is loaded
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !res_valid_q)
		else $error("result loaded over a pending result");

	a_commit_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && sts.rd_last) |=> (state_q == S_DRAIN))
		else $error("commit did not end in drain");

	a_drain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (res_valid_q && state_q == S_IDLE))
		else $error("commit finished without a result");

endmodule

>>> src/ppfu_dp.sv
// Datapath: packet tracking, window staging memory, frame memory and result register.
module ppfu_dp
	import ppfu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [4:0] pixel_x,
	input  logic [4:0] pixel_y,
	output logic [1:0] status,
	output logic [8:0] red,
	output logic [8:0] green,
	output logic [8:0] blue
);

	// packet tracking
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic              header_ok_q;
	logic [2:0]        part_q;
	logic [WIDX_W-1:0] widx_q;
	logic [2:0]        kidx_q;
	logic              len_ok;
	logic              stage_en;
	logic [2:0]        lane;

	// commit sequencing
	logic [STG_AW-1:0] rd_idx_q;
	logic [FRM_AW-1:0] wn_q;
	logic [FRM_AW-1:0] wn_s1;
	logic              wr_valid_s1;
	logic [FRM_AW-1:0] base;

	// memories
	logic [WIN_BYTES-1:0][7:0] stg_mem [WINDOWS_PER_PART];
	logic [WIN_BITS-1:0]       stg_rdata_s1;
	logic [WIN_BITS-1:0]       frm_mem [FRAME_WINDOWS];
	logic [FRAME_WINDOWS-1:0]  frm_vld_q;
	logic                      frm_we;

	// pixel read
	logic [FRM_AW-1:0]   rd_addr;
	logic                in_frame;
	logic [WIN_BITS-1:0] frm_rdata_s1;
	logic                frm_vld_s1;
	logic                in_frame_s1;
	logic [1:0]          quad_s1;
	logic [PIX_BITS-1:0] pix;

	// result register
	logic [1:0] status_q;
	logic [8:0] red_q, green_q, blue_q;

	assign cnt_nxt  = (cnt_q <= CNT_W'(PACKET_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign len_ok   = (cnt_nxt == CNT_W'(PACKET_BYTES));
	assign sts.pkt_good = len_ok && header_ok_q && (part_q != 3'd0);
	assign sts.rd_last  = (rd_idx_q == STG_AW'(WINDOWS_PER_PART - 1));

	assign stage_en = cmd.byte_take && (cnt_q > CNT_W'(1))
		&& (widx_q < WIDX_W'(WINDOWS_PER_PART));
	// first byte of a window lands in the top lane
	assign lane = 3'(WIN_BYTES - 1) - kidx_q;
	assign base = FRM_AW'((int'(part_q) - 1) * WINDOWS_PER_PART);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			header_ok_q <= 1'b0;
			part_q      <= '0;
			widx_q      <= '0;
			kidx_q      <= '0;
		end else if (cmd.byte_take) begin
			if (last_byte) begin
				cnt_q       <= '0;
				header_ok_q <= 1'b0;
				part_q      <= '0;
				widx_q      <= '0;
				kidx_q      <= '0;
			end else begin
				cnt_q <= cnt_nxt;
				if (cnt_q == CNT_W'(0)) begin
					header_ok_q <= (data_byte == HEADER_VALUE);
				end else if (cnt_q == CNT_W'(1)) begin
					part_q <= (data_byte >= 8'd1 && data_byte <= MAX_PART_B) ?
						data_byte[2:0] : 3'd0;
				end
				if (stage_en) begin
					if (kidx_q == 3'(WIN_BYTES - 1)) begin
						kidx_q <= '0;
						widx_q <= widx_q + WIDX_W'(1);
					end else begin
						kidx_q <= kidx_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en) begin
			stg_mem[widx_q[STG_AW-1:0]][lane] <= data_byte;
		end
		if (cmd.commit_step) begin
			stg_rdata_s1 <= stg_mem[rd_idx_q];
		end
	end

	// one staged window per cycle into the frame memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			wn_q        <= '0;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= cmd.commit_step;
			if (cmd.commit_start) begin
				rd_idx_q <= '0;
				wn_q     <= base;
			end else if (cmd.commit_step) begin
				rd_idx_q <= rd_idx_q + STG_AW'(1);
				wn_q     <= wn_q + FRM_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_step) begin
			wn_s1 <= wn_q;
		end
	end

	assign frm_we = wr_valid_s1 && (int'(wn_s1) < FRAME_WINDOWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_vld_q <= '0;
		end else if (frm_we) begin
			frm_vld_q[wn_s1] <= 1'b1;
		end
	end

	assign in_frame = ({1'b0, pixel_x} < 6'(FRAME_WIDTH))
		&& (int'(pixel_y) < FRAME_HEIGHT);
	assign rd_addr = in_frame ?
		FRM_AW'(int'(pixel_y[4:1]) * WINDOWS_PER_ROW + int'(pixel_x[4:1])) : '0;

	always_ff @(posedge clk) begin
		if (frm_we) begin
			frm_mem[wn_s1] <= stg_rdata_s1;
		end
		if (cmd.read_issue) begin
			frm_rdata_s1 <= frm_mem[rd_addr];
			frm_vld_s1   <= frm_vld_q[rd_addr];
			in_frame_s1  <= in_frame;
			quad_s1      <= {pixel_y[0], pixel_x[0]};
		end
	end

	always_comb begin
		case (quad_s1)
			2'b00:   pix = frm_rdata_s1[47:36];
			2'b01:   pix = frm_rdata_s1[35:24];
			2'b10:   pix = frm_rdata_s1[23:12];
			default: pix = frm_rdata_s1[11:0];
		endcase
		if (!(in_frame_s1 && frm_vld_s1)) begin
			pix = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_read) begin
			status_q <= ST_PIXEL_DATA;
			red_q    <= {pix[11:8], 5'b0};
			green_q  <= {pix[7:4], 5'b0};
			blue_q   <= {pix[3:0], 5'b0};
		end else if (cmd.load_reject || cmd.load_commit) begin
			status_q <= cmd.load_commit ? ST_OK_COMMIT :
				(len_ok ? ST_BAD_HEADER : ST_BAD_LENGTH);
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
		end
	end

	assign status = status_q;
	assign red    = red_q;
	assign green  = green_q;
	assign blue   = blue_q;

	a_wr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_s1 |-> (int'(wn_s1) < FRAME_WINDOWS))
		else $error("commit window outside frame");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PACKET_BYTES + 1))
		else $error("byte count past saturation");

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= WIDX_W'(WINDOWS_PER_PART))
		else $error("window index past staging area");

	a_kidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		kidx_q < 3'(WIN_BYTES))
		else $error("byte lane index out of range");

endmodule

>>> src/pixel_packet_frame_updater_unit.sv
// Top level of the pixel packet frame updater: controller plus datapath.
// A final byte that fails the length, header or part check gives its status result at once. A
// final byte of a good packet holds the input while the commit moves one staged 2x2 window a
// cycle through the staging memory read port into the frame memory write port. A pixel read
// passes through the registered read of the frame memory and then the result register. No new
// item is taken while a result waits in the output register. The frame store keeps one valid
// bit per window, so it reads as zero from reset on with no clearing pass.
module pixel_packet_frame_updater_unit
	import ppfu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [4:0] pixel_x,
	input  logic [4:0] pixel_y,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] status,
	output logic [8:0] red,
	output logic [8:0] green,
	output logic [8:0] blue
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ppfu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	ppfu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.status    (status),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the pixel packet frame updater: packet and read stimulus, frame predictor.
`timescale 1ns / 1ps

module tb_top;
	import ppfu_pkg::*;

	localparam int unsigned ITEM_TARGET = 1250;
	localparam int unsigned DRAIN_CYCLES = 64;

	typedef struct {
		status_t    status;
		logic [8:0] red;
		logic [8:0] green;
		logic [8:0] blue;
	} frame_reply_t;

	typedef enum {PK_GOOD, PK_BAD_ID, PK_NEAR_LEN} pkt_kind_t;

	class frame_scoreboard;
		int unsigned pkt_len;
		bit hdr_good;
		int unsigned part_no;
		bit [WIN_BITS-1:0] window_buf [WINDOWS_PER_PART];
		bit [PIX_BITS-1:0] frame_pix [FRAME_WIDTH * FRAME_HEIGHT];
		frame_reply_t awaited_replies [$];
		int unsigned errors;

		function int unsigned outstanding();
			return awaited_replies.size();
		endfunction

		function void note_item(bit act, bit [7:0] b, bit last, bit [4:0] x, bit [4:0] y);
			frame_reply_t rep;
			bit [PIX_BITS-1:0] pix;
			int unsigned off, wn, px, py, i, q;
			rep = '{ST_PIXEL_DATA, 9'd0, 9'd0, 9'd0};
			if (act) begin
				if (x < FRAME_WIDTH && y < FRAME_HEIGHT) begin
					pix = frame_pix[y * FRAME_WIDTH + x];
					rep.red = {pix[11:8], 5'd0};
					rep.green = {pix[7:4], 5'd0};
					rep.blue = {pix[3:0], 5'd0};
				end
				awaited_replies.push_back(rep);
				return;
			end
			if (pkt_len == 0) begin
				hdr_good = (b == HEADER_VALUE);
			end else if (pkt_len == 1) begin
				part_no = (b >= 1 && b <= MAX_PART) ? b : 0;
			end else begin
				off = pkt_len - 2;
				// bytes past the staging area are dropped
				if (off / WIN_BYTES < WINDOWS_PER_PART)
					window_buf[off / WIN_BYTES][WIN_BITS - 8 - 8 * (off % WIN_BYTES) +: 8] = b;
			end
			if (pkt_len <= PACKET_BYTES)
				pkt_len++;
			if (!last)
				return;
			if (pkt_len != PACKET_BYTES) begin
				rep.status = ST_BAD_LENGTH;
			end else if (!hdr_good || part_no == 0) begin
				rep.status = ST_BAD_HEADER;
			end else begin
				rep.status = ST_OK_COMMIT;
				for (i = 0; i < WINDOWS_PER_PART; i++) begin
					wn = (part_no - 1) * WINDOWS_PER_PART + i;
					// quadrants: top-left, top-right, bottom-left, bottom-right
					for (q = 0; q < 4; q++) begin
						px = (wn % WINDOWS_PER_ROW) * 2 + q % 2;
						py = (wn / WINDOWS_PER_ROW) * 2 + q / 2;
						if (px < FRAME_WIDTH && py < FRAME_HEIGHT)
							frame_pix[py * FRAME_WIDTH + px] =
								window_buf[i][WIN_BITS - PIX_BITS * (q + 1) +: PIX_BITS];
					end
				end
			end
			pkt_len = 0;
			hdr_good = 1'b0;
			part_no = 0;
			awaited_replies.push_back(rep);
		endfunction

		function void compare_field(string name, logic [8:0] want, logic [8:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [1:0] st, logic [8:0] r, logic [8:0] g, logic [8:0] bl);
			frame_reply_t want;
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d", $time, st);
				return;
			end
			want = awaited_replies.pop_front();
			compare_field("status", 9'(want.status), 9'(st));
			compare_field("red", want.red, r);
			compare_field("green", want.green, g);
			compare_field("blue", want.blue, bl);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       action = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic [4:0] pixel_x = 5'd0;
	logic [4:0] pixel_y = 5'd0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] status;
	logic [8:0] red;
	logic [8:0] green;
	logic [8:0] blue;

	frame_scoreboard sb = new();
	int unsigned items_sent = 0;
	int send_idle_pct = 23;
	int stall_pct = 56;

	pixel_packet_frame_updater_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(status, red, green, blue);
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_item(bit act, bit [7:0] b, bit last, bit [4:0] x, bit [4:0] y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		last_byte <= last;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(act, b, last, x, y);
		items_sent++;
	endtask

	// data_byte and last_byte are don't-care on a read
	task automatic send_read(bit [4:0] x, bit [4:0] y);
		send_item(1'b1, 8'($urandom()), 1'($urandom()), x, y);
	endtask

	task automatic send_packet(bit [7:0] hdr, bit [7:0] part, int unsigned len);
		int unsigned k;
		bit [7:0] b;
		for (k = 0; k < len; k++) begin
			// occasional read between bytes must not disturb assembly
			if ($urandom_range(0, 99) < 2)
				send_read(5'($urandom()), 5'($urandom()));
			b = (k == 0) ? hdr : (k == 1) ? part : 8'($urandom());
			send_item(1'b0, b, k == len - 1, 5'($urandom()), 5'($urandom()));
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		pkt_kind_t kind_cycle [4];
		int unsigned cycle_pos, part_rot, phase;
		bit [7:0] hdr, part;
		kind_cycle = '{PK_GOOD, PK_BAD_ID, PK_GOOD, PK_NEAR_LEN};
		cycle_pos = 0;
		part_rot = $urandom_range(0, MAX_PART - 1);
		phase = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// cleared frame, corners, rows past the frame
		send_read(5'd0, 5'd0);
		send_read(5'd31, 5'd25);
		send_read(5'd31, 5'd31);
		send_read(5'd0, 5'd26);
		// short packets: length is checked before header and part
		send_packet(HEADER_VALUE, 8'd1, 1);
		send_packet(8'hff, 8'd1, 1);
		send_packet(HEADER_VALUE, MAX_PART_B, 2);
		send_packet(8'h00, 8'h00, 3);
		send_item(1'b0, HEADER_VALUE, 1'b0, 5'd31, 5'd31);
		send_read(5'd16, 5'd13);
		send_item(1'b0, 8'hff, 1'b1, 5'd0, 5'd0);
		send_read(5'd15, 5'd12);
		drain();

		while (items_sent < ITEM_TARGET) begin
			if (phase < 2 && items_sent >= (phase + 1) * ITEM_TARGET / 3) begin
				phase++;
				drain();
				if (phase == 1) begin
					send_idle_pct = 56;
					stall_pct = 23;
				end else begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			end
			case (kind_cycle[cycle_pos % 4])
				PK_GOOD: begin
					send_packet(HEADER_VALUE, 8'(part_rot % MAX_PART + 1), PACKET_BYTES);
					part_rot++;
				end
				PK_BAD_ID: begin
					if ($urandom_range(0, 1)) begin
						hdr = 8'($urandom());
						if (hdr == HEADER_VALUE)
							hdr = 8'h00;
						part = 8'($urandom_range(1, MAX_PART));
					end else begin
						hdr = HEADER_VALUE;
						case ($urandom_range(0, 3))
							0: part = 8'h00;
							1: part = MAX_PART_B + 8'd1;
							2: part = 8'($urandom_range(MAX_PART + 1, 7));
							default: part = 8'($urandom_range(8, 255));
						endcase
					end
					send_packet(hdr, part, PACKET_BYTES);
				end
				default: begin
					case ($urandom_range(0, 2))
						0: send_packet(HEADER_VALUE, 8'($urandom_range(1, MAX_PART)),
							PACKET_BYTES - 1);
						1: send_packet(HEADER_VALUE, 8'($urandom_range(1, MAX_PART)),
							PACKET_BYTES + 1);
						default: send_packet(HEADER_VALUE, 8'($urandom_range(1, MAX_PART)),
							$urandom_range(PACKET_BYTES + 2, PACKET_BYTES + 16));
					endcase
				end
			endcase
			cycle_pos++;
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 8))
						send_read(5'($urandom()), 5'($urandom()));
				end else begin
					hdr = $urandom_range(0, 1) ? HEADER_VALUE : 8'($urandom());
					send_packet(hdr, 8'($urandom_range(0, 7)), $urandom_range(1, 12));
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> pixel_packet_frame_updater_unit.f
src/ppfu_pkg.sv
src/ppfu_ctrl.sv
src/ppfu_dp.sv
src/pixel_packet_frame_updater_unit.sv
dv/tb_top.sv
